>>> src/hufd_pkg.sv
// Shared types, codes and defaults for the Huffman tree build and decode core.
// Used by every module of the block; depends on nothing.
package hufd_pkg;

  localparam int SYMBOLS_DEF   = 256;
  localparam int FREQ_BITS_DEF = 24;
  localparam int CMD_DEPTH     = 4;
  localparam int OUT_DEPTH     = 8;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_DECODE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_NOTREE = 2'd2
  } sts_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  symbol_index;
    logic [23:0] frequency;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_status;
    sts_t       status;
    logic       message_done;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic     vld;
    in_item_t item;
  } cmd_chan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_INS_RD,
    ST_INS_CMP,
    ST_LEAVES_END,
    ST_MERGE_CHK,
    ST_POP_A,
    ST_POP_B,
    ST_ROOT,
    ST_ROOT_REC,
    ST_STATUS,
    ST_DEC_BIT,
    ST_DEC_CHK,
    ST_DEC_END
  } eng_state_t;

endpackage

>>> src/huffman_tree_build_and_decode_core.sv
// Top level of the Huffman tree build and decode core.
// Depends on hufd_pkg, hufd_front, hufd_engine and hufd_out_fifo.
//
// Requests enter through a queue-style port (in_push / in_full). A load request
// writes one symbol frequency; a build request forms the tree and returns one
// status result; a decode request walks the tree over up to eight bits MSB
// first, stopping at the message length, and returns one result per symbol
// found, or a no-tree status; a request's final result is flagged by last.
// Results leave through a queue-style port (out_empty / out_pop). The message
// length register is written on cfg_valid with cfg_ready high; the user must
// write it only while the block is idle, which the block does not enforce.
// Decoding does a registered read of the node memory on each tree step; a
// one-symbol tree emits its symbol for each bit with no walk. A build scans all
// symbols, inserts each leaf into the sorted queue by moving heavier entries up,
// then merges the two lightest entries and inserts the result until one root
// is left. Reset clears the frequency table at once through per-entry valid
// bits and marks no tree built. A stalled receiver fills the result queue, the
// engine then holds at its next result, and the request queue fills until
// in_full rises.
module huffman_tree_build_and_decode_core #(
  parameter int SYMBOLS   = hufd_pkg::SYMBOLS_DEF,
  parameter int FREQ_BITS = hufd_pkg::FREQ_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  hufd_pkg::in_item_t  in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output hufd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_data
);
  import hufd_pkg::*;

  cmd_chan_t   cmd_chan;
  logic        cmd_pop;
  logic [23:0] msg_len_r, msg_len_nxt;
  logic        res_full;
  logic        res_push;
  out_item_t   res_item;

  assign cfg_ready   = 1'b1;
  assign msg_len_nxt = (cfg_valid && cfg_ready) ? cfg_data : msg_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= '0;
    end else begin
      msg_len_r <= msg_len_nxt;
    end
  end

  hufd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_chan (cmd_chan),
    .cmd_pop  (cmd_pop)
  );

  hufd_engine #(
    .SYMBOLS   (SYMBOLS),
    .FREQ_BITS (FREQ_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_chan (cmd_chan),
    .cmd_pop  (cmd_pop),
    .msg_len  (msg_len_r),
    .out_full (res_full),
    .out_push (res_push),
    .out_item (res_item)
  );

  hufd_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_item),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

endmodule

>>> src/hufd_front.sv
// Front end: accepts requests, drops unused commands and queues the rest.
// Depends on hufd_pkg.
module hufd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  hufd_pkg::in_item_t  in_data,
  output logic                in_full,
  output hufd_pkg::cmd_chan_t cmd_chan,
  input  logic                cmd_pop
);
  import hufd_pkg::*;

  localparam int AB = $clog2(CMD_DEPTH);

  in_item_t        fifo_r [CMD_DEPTH];
  logic [AB:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AB:0]     rd_ptr_r, rd_ptr_nxt;
  logic            wr_en;
  logic            rd_en;

  assign in_full = (wr_ptr_r[AB] != rd_ptr_r[AB]) && (wr_ptr_r[AB-1:0] == rd_ptr_r[AB-1:0]);
  assign wr_en   = in_push && !in_full && (in_data.cmd != CMD_NONE);
  assign cmd_chan.vld  = (wr_ptr_r != rd_ptr_r);
  assign cmd_chan.item = fifo_r[rd_ptr_r[AB-1:0]];
  assign rd_en   = cmd_pop && cmd_chan.vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (AB+1)'(wr_en);
    rd_ptr_nxt = rd_ptr_r + (AB+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r[AB-1:0]] <= in_data;
    end
  end

endmodule

>>> src/hufd_out_fifo.sv
// Result queue between the engine and the result channel.
// Depends on hufd_pkg.
module hufd_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hufd_pkg::out_item_t din,
  output logic                full,
  input  logic                pop,
  output hufd_pkg::out_item_t dout,
  output logic                empty
);
  import hufd_pkg::*;

  localparam int AB = $clog2(OUT_DEPTH);

  out_item_t   fifo_r [OUT_DEPTH];
  logic [AB:0] wr_ptr_r, wr_ptr_nxt;
  logic [AB:0] rd_ptr_r, rd_ptr_nxt;
  logic        wr_en;
  logic        rd_en;

  assign full  = (wr_ptr_r[AB] != rd_ptr_r[AB]) && (wr_ptr_r[AB-1:0] == rd_ptr_r[AB-1:0]);
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign dout  = fifo_r[rd_ptr_r[AB-1:0]];
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (AB+1)'(wr_en);
    rd_ptr_nxt = rd_ptr_r + (AB+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r[AB-1:0]] <= din;
    end
  end

endmodule

>>> src/hufd_engine.sv
// Back end: frequency table, tree build sequencer with a sorted queue, and tree walk.
// Depends on hufd_pkg; fed by hufd_front, drains into hufd_out_fifo.
module hufd_engine #(
  parameter int SYMBOLS   = hufd_pkg::SYMBOLS_DEF,
  parameter int FREQ_BITS = hufd_pkg::FREQ_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hufd_pkg::cmd_chan_t cmd_chan,
  output logic                cmd_pop,
  input  logic [23:0]         msg_len,
  input  logic                out_full,
  output logic                out_push,
  output hufd_pkg::out_item_t out_item
);
  import hufd_pkg::*;

  localparam int SB    = $clog2(SYMBOLS);
  localparam int QD    = 2 ** SB;
  localparam int NODES = 2 * SYMBOLS - 1;
  localparam int NB    = $clog2(NODES);

  typedef struct packed {
    logic [NB-1:0] node;
    logic [31:0]   w;
  } q_ent_t;

  typedef struct packed {
    logic          leaf;
    logic [NB-1:0] left;
    logic [NB-1:0] right;
  } node_rec_t;

  eng_state_t    state_r, state_nxt;
  logic [SB:0]   scan_s_r, scan_s_nxt;
  logic [NB-1:0] node_cnt_r, node_cnt_nxt;
  logic [SB-1:0] q_head_r, q_head_nxt;
  logic [SB:0]   q_cnt_r, q_cnt_nxt;
  logic [SB:0]   ins_pos_r, ins_pos_nxt;
  q_ent_t        ins_ent_r, ins_ent_nxt;
  logic          leaf_ph_r, leaf_ph_nxt;
  q_ent_t        a_ent_r, a_ent_nxt;
  logic [NB-1:0] root_idx_r, root_idx_nxt;
  node_rec_t     root_rec_r, root_rec_nxt;
  node_rec_t     walk_rec_r, walk_rec_nxt;
  logic          tree_rdy_r, tree_rdy_nxt;
  logic [23:0]   dec_cnt_r, dec_cnt_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [3:0]    bits_r, bits_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  out_item_t     pend_r, pend_nxt;
  sts_t          st_code_r, st_code_nxt;

  logic [FREQ_BITS-1:0] freq_mem [SYMBOLS];
  logic [SYMBOLS-1:0]   freq_vld_r;
  logic [FREQ_BITS-1:0] freq_rd_r;
  logic                 freq_rd_vld_r;
  logic                 freq_we;
  logic [SB-1:0]        freq_waddr;
  logic [SB-1:0]        freq_raddr;

  q_ent_t        q_mem [QD];
  q_ent_t        q_rd_r;
  logic          q_we;
  logic [SB-1:0] q_waddr;
  q_ent_t        q_wdata;
  logic [SB-1:0] q_raddr;

  node_rec_t     node_mem [NODES];
  node_rec_t     node_rd_r;
  logic          node_we;
  logic [NB-1:0] node_waddr;
  node_rec_t     node_wdata;
  logic [NB-1:0] node_raddr;

  logic          load_ok;
  logic          can_pop;
  logic          freq_nz;
  logic          bit_val;
  logic [NB-1:0] child;
  logic [32:0]   wsum;
  logic [31:0]   wmerge;
  logic          dec_stop;
  logic          emit;
  logic [7:0]    emit_sym;
  out_item_t     emit_item;

  assign load_ok  = ({1'b0, cmd_chan.item.symbol_index} < 9'(SYMBOLS));
  assign can_pop  = cmd_chan.vld &&
                    (cmd_chan.item.cmd != CMD_DECODE || tree_rdy_r || !out_full);
  assign freq_nz  = freq_rd_vld_r && (freq_rd_r != '0);
  assign bit_val  = byte_r[7];
  assign child    = bit_val ? walk_rec_r.right : walk_rec_r.left;
  assign wsum     = {1'b0, a_ent_r.w} + {1'b0, q_rd_r.w};
  assign wmerge   = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
  assign dec_stop = (bits_r == 4'd0) || (dec_cnt_r >= msg_len);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (can_pop) begin
          case (cmd_chan.item.cmd)
            CMD_BUILD:  state_nxt = ST_SCAN_RD;
            CMD_DECODE: state_nxt = tree_rdy_r ? ST_DEC_BIT : ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD:    state_nxt = (scan_s_r == (SB+1)'(SYMBOLS)) ? ST_LEAVES_END : ST_SCAN_CHK;
      ST_SCAN_CHK:   state_nxt = freq_nz ? ST_INS_RD : ST_SCAN_RD;
      ST_INS_RD: begin
        if (ins_pos_r == '0) begin
          state_nxt = leaf_ph_r ? ST_SCAN_RD : ST_MERGE_CHK;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (q_rd_r.w > ins_ent_r.w) begin
          state_nxt = ST_INS_RD;
        end else begin
          state_nxt = leaf_ph_r ? ST_SCAN_RD : ST_MERGE_CHK;
        end
      end
      ST_LEAVES_END: state_nxt = (q_cnt_r == '0) ? ST_STATUS : ST_MERGE_CHK;
      ST_MERGE_CHK:  state_nxt = (q_cnt_r > (SB+1)'(1)) ? ST_POP_A : ST_ROOT;
      ST_POP_A:      state_nxt = ST_POP_B;
      ST_POP_B:      state_nxt = ST_INS_RD;
      ST_ROOT:       state_nxt = ST_ROOT_REC;
      ST_ROOT_REC:   state_nxt = ST_STATUS;
      ST_STATUS:     state_nxt = out_full ? ST_STATUS : ST_IDLE;
      ST_DEC_BIT: begin
        if (dec_stop) begin
          state_nxt = ST_DEC_END;
        end else if (!(out_full && pend_vld_r) && !root_rec_r.leaf) begin
          state_nxt = ST_DEC_CHK;
        end
      end
      ST_DEC_CHK:    state_nxt = ST_DEC_BIT;
      ST_DEC_END:    state_nxt = (pend_vld_r && out_full) ? ST_DEC_END : ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_s_nxt   = scan_s_r;
    node_cnt_nxt = node_cnt_r;
    q_head_nxt   = q_head_r;
    q_cnt_nxt    = q_cnt_r;
    ins_pos_nxt  = ins_pos_r;
    ins_ent_nxt  = ins_ent_r;
    leaf_ph_nxt  = leaf_ph_r;
    a_ent_nxt    = a_ent_r;
    root_idx_nxt = root_idx_r;
    root_rec_nxt = root_rec_r;
    walk_rec_nxt = walk_rec_r;
    tree_rdy_nxt = tree_rdy_r;
    dec_cnt_nxt  = dec_cnt_r;
    byte_nxt     = byte_r;
    bits_nxt     = bits_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    st_code_nxt  = st_code_r;
    cmd_pop      = 1'b0;
    out_push     = 1'b0;
    out_item     = pend_r;
    freq_we      = 1'b0;
    freq_waddr   = cmd_chan.item.symbol_index[SB-1:0];
    freq_raddr   = scan_s_r[SB-1:0];
    q_we         = 1'b0;
    q_waddr      = q_head_r + ins_pos_r[SB-1:0];
    q_wdata      = ins_ent_r;
    q_raddr      = q_head_r;
    node_we      = 1'b0;
    node_waddr   = node_cnt_r;
    node_wdata   = '{leaf: 1'b1, left: NB'(scan_s_r), right: '0};
    node_raddr   = child;
    emit         = 1'b0;
    emit_sym     = 8'(root_rec_r.left);
    emit_item    = '{symbol: 8'(root_rec_r.left), is_status: 1'b0, status: STS_OK,
                     message_done: 1'b0, last: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (can_pop) begin
          cmd_pop = 1'b1;
          case (cmd_chan.item.cmd)
            CMD_LOAD: begin
              freq_we = load_ok;
            end
            CMD_BUILD: begin
              scan_s_nxt   = '0;
              node_cnt_nxt = '0;
              q_head_nxt   = '0;
              q_cnt_nxt    = '0;
              leaf_ph_nxt  = 1'b1;
              dec_cnt_nxt  = '0;
            end
            CMD_DECODE: begin
              if (tree_rdy_r) begin
                byte_nxt = cmd_chan.item.data_byte;
                bits_nxt = 4'd8;
              end else begin
                out_push = 1'b1;
                out_item = '{symbol: 8'd0, is_status: 1'b1, status: STS_NOTREE,
                             message_done: 1'b0, last: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_CHK: begin
        scan_s_nxt = scan_s_r + (SB+1)'(1);
        if (freq_nz) begin
          node_we      = 1'b1;
          ins_ent_nxt  = '{node: node_cnt_r, w: 32'(freq_rd_r)};
          ins_pos_nxt  = q_cnt_r;
          node_cnt_nxt = node_cnt_r + NB'(1);
        end
      end
      ST_INS_RD: begin
        q_raddr = q_head_r + ins_pos_r[SB-1:0] - SB'(1);
        if (ins_pos_r == '0) begin
          q_we      = 1'b1;
          q_cnt_nxt = q_cnt_r + (SB+1)'(1);
        end
      end
      ST_INS_CMP: begin
        q_we = 1'b1;
        if (q_rd_r.w > ins_ent_r.w) begin
          q_wdata     = q_rd_r;
          ins_pos_nxt = ins_pos_r - (SB+1)'(1);
        end else begin
          q_cnt_nxt = q_cnt_r + (SB+1)'(1);
        end
      end
      ST_LEAVES_END: begin
        leaf_ph_nxt = 1'b0;
        if (q_cnt_r == '0) begin
          tree_rdy_nxt = 1'b0;
          root_idx_nxt = '0;
          st_code_nxt  = STS_EMPTY;
        end
      end
      ST_POP_A: begin
        a_ent_nxt  = q_rd_r;
        q_head_nxt = q_head_r + SB'(1);
        q_cnt_nxt  = q_cnt_r - (SB+1)'(1);
        q_raddr    = q_head_r + SB'(1);
      end
      ST_POP_B: begin
        q_head_nxt   = q_head_r + SB'(1);
        q_cnt_nxt    = q_cnt_r - (SB+1)'(1);
        node_we      = 1'b1;
        node_wdata   = '{leaf: 1'b0, left: a_ent_r.node, right: q_rd_r.node};
        ins_ent_nxt  = '{node: node_cnt_r, w: wmerge};
        ins_pos_nxt  = q_cnt_r - (SB+1)'(1);
        node_cnt_nxt = node_cnt_r + NB'(1);
      end
      ST_ROOT: begin
        root_idx_nxt = q_rd_r.node;
        node_raddr   = q_rd_r.node;
      end
      ST_ROOT_REC: begin
        root_rec_nxt = node_rd_r;
        walk_rec_nxt = node_rd_r;
        tree_rdy_nxt = 1'b1;
        st_code_nxt  = STS_OK;
      end
      ST_STATUS: begin
        out_push = !out_full;
        out_item = '{symbol: 8'd0, is_status: 1'b1, status: st_code_r,
                     message_done: 1'b0, last: 1'b1};
      end
      ST_DEC_BIT: begin
        if (!dec_stop && !(out_full && pend_vld_r)) begin
          byte_nxt = {byte_r[6:0], 1'b0};
          bits_nxt = bits_r - 4'd1;
          if (root_rec_r.leaf) begin
            emit     = 1'b1;
            emit_sym = 8'(root_rec_r.left);
          end
        end
      end
      ST_DEC_CHK: begin
        if (node_rd_r.leaf) begin
          emit         = 1'b1;
          emit_sym     = 8'(node_rd_r.left);
          walk_rec_nxt = root_rec_r;
        end else begin
          walk_rec_nxt = node_rd_r;
        end
      end
      ST_DEC_END: begin
        if (pend_vld_r && !out_full) begin
          out_push     = 1'b1;
          out_item     = pend_r;
          out_item.last = 1'b1;
          pend_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (emit) begin
      emit_item = '{symbol: emit_sym, is_status: 1'b0, status: STS_OK,
                    message_done: ((dec_cnt_r + 24'd1) == msg_len), last: 1'b0};
      dec_cnt_nxt  = dec_cnt_r + 24'd1;
      out_push     = pend_vld_r;
      out_item     = pend_r;
      pend_nxt     = emit_item;
      pend_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tree_rdy_r <= 1'b0;
      dec_cnt_r  <= '0;
      pend_vld_r <= 1'b0;
      root_idx_r <= '0;
      q_cnt_r    <= '0;
      q_head_r   <= '0;
      node_cnt_r <= '0;
      leaf_ph_r  <= 1'b0;
      freq_vld_r <= '0;
    end else begin
      state_r    <= state_nxt;
      tree_rdy_r <= tree_rdy_nxt;
      dec_cnt_r  <= dec_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      root_idx_r <= root_idx_nxt;
      q_cnt_r    <= q_cnt_nxt;
      q_head_r   <= q_head_nxt;
      node_cnt_r <= node_cnt_nxt;
      leaf_ph_r  <= leaf_ph_nxt;
      if (freq_we) begin
        freq_vld_r[freq_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_s_r   <= scan_s_nxt;
    ins_pos_r  <= ins_pos_nxt;
    ins_ent_r  <= ins_ent_nxt;
    a_ent_r    <= a_ent_nxt;
    root_rec_r <= root_rec_nxt;
    walk_rec_r <= walk_rec_nxt;
    byte_r     <= byte_nxt;
    bits_r     <= bits_nxt;
    pend_r     <= pend_nxt;
    st_code_r  <= st_code_nxt;
  end

  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[freq_waddr] <= FREQ_BITS'(cmd_chan.item.frequency);
    end
    freq_rd_r     <= freq_mem[freq_raddr];
    freq_rd_vld_r <= freq_vld_r[freq_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_r <= q_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_r <= node_mem[node_raddr];
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("result pushed into a full queue");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (SB+1)'(SYMBOLS)) else $error("sorted queue overflow");

  a_walk_internal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC_CHK) |-> (!root_rec_r.leaf && !walk_rec_r.leaf))
    else $error("tree walk stepped from a leaf");

  a_ready_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tree_rdy_r) |-> $past(state_r == ST_ROOT_REC))
    else $error("tree marked ready outside the root capture");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for huffman_tree_build_and_decode_core.
// It depends on hufd_pkg and the core RTL. A scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_top;
  import hufd_pkg::*;

  class huff_scoreboard;
    logic [23:0] msg_len;
    logic [23:0] freq_tab [256];
    logic [31:0] wt [511];
    logic [8:0]  lchild [511];
    logic [8:0]  rchild [511];
    logic [8:0]  leaf_sym [511];
    logic [8:0]  sq [256];
    int          sq_cnt;
    logic [8:0]  root;
    logic [8:0]  walk;
    logic [23:0] dec_cnt;
    bit          have_tree;
    out_item_t   pending_q [$];
    int          errors;

    function new();
      msg_len = 0;
      foreach (freq_tab[i]) freq_tab[i] = 0;
      sq_cnt = 0;
      root = 0;
      walk = 0;
      dec_cnt = 0;
      have_tree = 0;
      errors = 0;
    endfunction

    function void sq_insert(logic [8:0] n);
      int pos;
      pos = sq_cnt;
      if (sq_cnt >= 256) return;
      while (pos > 0 && wt[sq[pos-1]] > wt[n]) begin
        sq[pos] = sq[pos-1];
        pos--;
      end
      sq[pos] = n;
      sq_cnt++;
    endfunction

    function logic [8:0] sq_pop();
      logic [8:0] h;
      if (sq_cnt == 0) return '0;
      h = sq[0];
      for (int i = 0; i < sq_cnt - 1; i++) sq[i] = sq[i+1];
      sq_cnt--;
      return h;
    endfunction

    function sts_t build_tree();
      int cnt;
      logic [8:0] a;
      logic [8:0] b;
      logic [32:0] sum;
      cnt = 0;
      sq_cnt = 0;
      for (int s = 0; s < 256; s++) begin
        if (freq_tab[s] != 0) begin
          wt[cnt] = 32'(freq_tab[s]);
          lchild[cnt] = '0;
          rchild[cnt] = '0;
          leaf_sym[cnt] = 9'h100 | 9'(s);
          sq_insert(9'(cnt));
          cnt++;
        end
      end
      dec_cnt = 0;
      if (sq_cnt == 0) begin
        have_tree = 0;
        root = 0;
        walk = 0;
        return STS_EMPTY;
      end
      while (sq_cnt > 1 && cnt < 511) begin
        a = sq_pop();
        b = sq_pop();
        sum = {1'b0, wt[a]} + {1'b0, wt[b]};
        wt[cnt] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        lchild[cnt] = a;
        rchild[cnt] = b;
        leaf_sym[cnt] = '0;
        sq_insert(9'(cnt));
        cnt++;
      end
      root = sq_pop();
      walk = root;
      have_tree = 1;
      return STS_OK;
    endfunction

    function void add_result(logic [7:0] sym, logic is_st, sts_t st, logic done);
      out_item_t r;
      r.symbol = sym;
      r.is_status = is_st;
      r.status = st;
      r.message_done = done;
      r.last = 0;
      pending_q.push_back(r);
    endfunction

    function void note_request(in_item_t it);
      int n;
      logic [8:0] cur;
      n = 0;
      case (it.cmd)
        CMD_LOAD: freq_tab[it.symbol_index] = it.frequency;
        CMD_BUILD: begin
          add_result(8'd0, 1'b1, build_tree(), 1'b0);
          n = 1;
        end
        CMD_DECODE: begin
          if (!have_tree) begin
            add_result(8'd0, 1'b1, STS_NOTREE, 1'b0);
            n = 1;
          end else begin
            for (int i = 7; i >= 0 && dec_cnt < msg_len; i--) begin
              cur = walk;
              if (!leaf_sym[root][8]) cur = it.data_byte[i] ? rchild[cur] : lchild[cur];
              else cur = root;
              if (leaf_sym[cur][8]) begin
                dec_cnt = dec_cnt + 24'd1;
                add_result(leaf_sym[cur][7:0], 1'b0, STS_OK, dec_cnt == msg_len);
                n++;
                walk = root;
              end else begin
                walk = cur;
              end
            end
          end
        end
        default: ;
      endcase
      if (n > 0) pending_q[$].last = 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.symbol !== exp_r.symbol)
        $display("%0t: symbol expected %0d actual %0d", $time, exp_r.symbol, got.symbol);
      if (got.is_status !== exp_r.is_status)
        $display("%0t: is_status expected %0b actual %0b", $time, exp_r.is_status,
                 got.is_status);
      if (got.status !== exp_r.status)
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
      if (got.message_done !== exp_r.message_done)
        $display("%0t: message_done expected %0b actual %0b", $time, exp_r.message_done,
                 got.message_done);
      if (got.last !== exp_r.last)
        $display("%0t: last expected %0b actual %0b", $time, exp_r.last, got.last);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  localparam int LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  in_item_t    in_data;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;

  huff_scoreboard sb;
  int hold_cycles;
  int burst_left;
  bit no_gaps;

  huffman_tree_build_and_decode_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int c = 0; c < LIMIT; c++) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic idle_gap(int n);
    @(negedge clk);
    in_push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send(in_item_t it);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        idle_gap($urandom_range(1, 6));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    sb.note_request(it);
  endtask

  function automatic in_item_t make_req(cmd_t c, logic [7:0] idx, logic [23:0] f,
                                        logic [7:0] b);
    in_item_t it;
    it.cmd = c;
    it.symbol_index = idx;
    it.frequency = f;
    it.data_byte = b;
    return it;
  endfunction

  function automatic in_item_t rand_req(cmd_t c);
    return make_req(c, 8'($urandom_range(0, 255)), 24'($urandom),
                    8'($urandom_range(0, 255)));
  endfunction

  task automatic wait_idle();
    idle_gap(1);
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_msg_len(logic [23:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.msg_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load(logic [7:0] idx, logic [23:0] f);
    send(make_req(CMD_LOAD, idx, f, 8'($urandom_range(0, 255))));
  endtask

  initial begin
    logic [23:0] f;
    int n_items;
    sb = new();
    rst_n = 0;
    in_push = 0;
    in_data = '0;
    out_pop = 0;
    cfg_valid = 0;
    cfg_data = '0;
    hold_cycles = 0;
    burst_left = 0;
    no_gaps = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    write_msg_len(24'd0);
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'hA5));
    send(make_req(CMD_BUILD, 8'hFF, 24'hFFFFFF, 8'h00));
    send(make_req(CMD_NONE, 8'hFF, 24'hFFFFFF, 8'hFF));
    load(8'd0, 24'hFFFFFF);
    send(make_req(CMD_BUILD, 8'h00, 24'h0, 8'h00));
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'hFF));
    write_msg_len(24'hFFFFFF);
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'hFF));
    send(make_req(CMD_DECODE, 8'hFF, 24'hFFFFFF, 8'h00));
    load(8'd255, 24'd1);
    load(8'd1, 24'hFFFFFF);
    load(8'd7, 24'd1);
    send(make_req(CMD_BUILD, 8'h00, 24'h0, 8'h00));
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'h00));
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'hFF));
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'h5C));
    load(8'd0, 24'd0);
    load(8'd1, 24'd0);
    write_msg_len(24'd3);
    send(make_req(CMD_BUILD, 8'h00, 24'h0, 8'h00));
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'hFF));
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'h6D));
    send(make_req(CMD_DECODE, 8'h00, 24'h0, 8'h00));

    n_items = 0;
    for (int ph = 0; n_items < 80; ph++) begin
      no_gaps = (ph % 3 == 2);
      write_msg_len((ph % 4 == 3 || ph == 2) ? 24'hFFFFFF : 24'($urandom_range(1, 40)));
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 3))
          0: f = 24'($urandom);
          1: f = 0;
          default: f = 24'($urandom_range(1, 20));
        endcase
        load(8'($urandom_range(0, 255)), f);
        n_items++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send(rand_req(CMD_NONE));
        n_items++;
      end
      if ($urandom_range(0, 7) != 0) begin
        send(rand_req(CMD_BUILD));
        n_items++;
      end
      if (ph == 2) hold_cycles = 600;
      repeat ((ph == 2) ? 20 : $urandom_range(2, 8)) begin
        send(rand_req(CMD_DECODE));
        n_items++;
      end
    end

    idle_gap(1);
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/hufd_pkg.sv
src/hufd_front.sv
src/hufd_out_fifo.sv
src/hufd_engine.sv
src/huffman_tree_build_and_decode_core.sv
dv/tb_top.sv
